// File: rtl/atapio_pkg.sv
// Shared types, codes and constants of the ATA PIO LBA28 transfer sequencer.
// Used by every module below the top level and by the top level itself.
package atapio_pkg;

    // Port payloads
    typedef struct packed {
        logic [1:0]  command;
        logic        is_write;
        logic        drive;
        logic [27:0] lba;
        logic [15:0] sector_count;
        logic [7:0]  status_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  reg_offset;
        logic [7:0]  value;
        logic [16:0] word_count;
        logic        last;
    } out_item_t;

    // Input commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_INTR  = 2'd1;
    localparam logic [1:0] CMD_STAT  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TIMEOUT  = 1'b0;
    localparam logic CFG_LAST_LBA = 1'b1;

    localparam logic [11:0] TIMEOUT_RESET  = 12'd3000;
    localparam logic [27:0] LAST_LBA_RESET = 28'd163839;

    // Result kinds
    localparam logic [2:0] K_REG    = 3'd0;
    localparam logic [2:0] K_RBURST = 3'd1;
    localparam logic [2:0] K_WBURST = 3'd2;
    localparam logic [2:0] K_DONE   = 3'd3;
    localparam logic [2:0] K_ERR    = 3'd4;
    localparam logic [2:0] K_ACK    = 3'd5;

    // Error codes
    localparam logic [1:0] ERR_TIMEOUT = 2'd0;
    localparam logic [1:0] ERR_NO_DRQ  = 2'd1;
    localparam logic [1:0] ERR_BAD_REQ = 2'd2;

    // Task-file register offsets
    localparam logic [2:0] REG_NONE     = 3'd0;
    localparam logic [2:0] REG_COUNT    = 3'd2;
    localparam logic [2:0] REG_LBA_LO   = 3'd3;
    localparam logic [2:0] REG_LBA_MID  = 3'd4;
    localparam logic [2:0] REG_LBA_HI   = 3'd5;
    localparam logic [2:0] REG_DRV_HEAD = 3'd6;
    localparam logic [2:0] REG_COMMAND  = 3'd7;

    // Bus constants
    localparam logic [7:0] STAT_BSY  = 8'h80;
    localparam logic [7:0] STAT_DRQ  = 8'h08;
    localparam logic [7:0] DEV_FIXED = 8'hA0;
    localparam logic [7:0] DEV_LBA   = 8'h40;
    localparam logic [7:0] DEV_SLAVE = 8'h10;
    localparam logic [7:0] ATA_READ  = 8'h20;
    localparam logic [7:0] ATA_WRITE = 8'h30;

    localparam logic [8:0] MAX_CHUNK_SECTORS = 9'd256;
    localparam int         SECTOR_SHIFT      = 8;   // 256 words per sector

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RD_WAIT_INT,
        PH_RD_POLL,
        PH_WR_POLL,
        PH_WR_WAIT_INT
    } phase_t;

    // Result slots of one job, in the order in which they leave the block
    localparam int SLOT_N = 11;
    localparam logic [3:0] SL_ERR   = 4'd0;
    localparam logic [3:0] SL_ACK   = 4'd1;
    localparam logic [3:0] SL_DEV   = 4'd2;
    localparam logic [3:0] SL_BURST = 4'd3;
    localparam logic [3:0] SL_CNT   = 4'd4;
    localparam logic [3:0] SL_LBA0  = 4'd5;
    localparam logic [3:0] SL_LBA1  = 4'd6;
    localparam logic [3:0] SL_LBA2  = 4'd7;
    localparam logic [3:0] SL_DEVC  = 4'd8;
    localparam logic [3:0] SL_CMD   = 4'd9;
    localparam logic [3:0] SL_DONE  = 4'd10;

    // Work handed from the front part to the back part
    typedef struct packed {
        logic        has_err;
        logic [1:0]  err_code;
        logic        has_ack;
        logic        has_dev;
        logic        has_burst;
        logic        burst_wr;
        logic [16:0] words;
        logic        has_chunk;
        logic        slave;
        logic        wr;
        logic [7:0]  count_byte;
        logic [27:0] lba;
        logic        has_done;
    } job_t;

endpackage

// File: rtl/atapio_front.sv
// Front part: accepts input words, holds the transfer state and configuration,
// and turns each word into a job for the back part. Depends on atapio_pkg.
module atapio_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [27:0]          cfg_data,
    input  logic                 acc,
    input  atapio_pkg::in_item_t item,
    output logic                 push,
    output atapio_pkg::job_t     job
);

    logic [11:0]        timeout_reg;
    logic [27:0]        last_lba_reg;

    atapio_pkg::phase_t phase_reg, phase_next;
    logic               write_mode_reg, write_mode_next;
    logic               slave_reg, slave_next;
    logic [27:0]        cur_lba_reg, cur_lba_next;
    logic [15:0]        rem_reg, rem_next;
    logic [8:0]         chunk_reg, chunk_next;
    logic [11:0]        poll_reg, poll_next;
    logic               expect_reg, expect_next;

    logic               start_bad, polling, bsy, drq, timeout_hit;
    logic [12:0]        poll_inc;
    logic [15:0]        fin_rem;
    logic               fin_done;
    logic [8:0]         fin_chunk, start_chunk;
    logic [27:0]        fin_lba;

    always_comb
    begin
        start_bad = (phase_reg != atapio_pkg::PH_IDLE) || (item.sector_count == 16'd0)
                    || (item.lba > last_lba_reg)
                    || (({1'b0, item.lba} + {13'd0, item.sector_count}) > 29'h1000_0000);
        polling   = (phase_reg == atapio_pkg::PH_RD_POLL) || (phase_reg == atapio_pkg::PH_WR_POLL);
        bsy       = (item.status_byte & atapio_pkg::STAT_BSY) != 8'd0;
        drq       = (item.status_byte & atapio_pkg::STAT_DRQ) != 8'd0;
        poll_inc  = {1'b0, poll_reg} + 13'd1;
        timeout_hit = poll_inc >= {1'b0, timeout_reg};
        // The remaining count is kept rather than the sectors done, so the end of
        // a transfer is an equality test.
        fin_rem   = rem_reg - {7'd0, chunk_reg};
        fin_done  = rem_reg == {7'd0, chunk_reg};
        fin_chunk = (fin_rem > {7'd0, atapio_pkg::MAX_CHUNK_SECTORS})
                    ? atapio_pkg::MAX_CHUNK_SECTORS : fin_rem[8:0];
        fin_lba   = cur_lba_reg + {19'd0, chunk_reg};
        start_chunk = (item.sector_count > {7'd0, atapio_pkg::MAX_CHUNK_SECTORS})
                      ? atapio_pkg::MAX_CHUNK_SECTORS : item.sector_count[8:0];
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (acc)
        begin
            case (item.command)
                atapio_pkg::CMD_START:
                begin
                    if (!start_bad)
                        phase_next = item.is_write ? atapio_pkg::PH_WR_POLL
                                                   : atapio_pkg::PH_RD_WAIT_INT;
                end
                atapio_pkg::CMD_INTR:
                begin
                    if (expect_reg && phase_reg == atapio_pkg::PH_RD_WAIT_INT)
                        phase_next = atapio_pkg::PH_RD_POLL;
                    else if (expect_reg && phase_reg == atapio_pkg::PH_WR_WAIT_INT)
                        phase_next = fin_done ? atapio_pkg::PH_IDLE : atapio_pkg::PH_WR_POLL;
                end
                atapio_pkg::CMD_STAT:
                begin
                    if (polling)
                    begin
                        if (bsy)
                        begin
                            if (timeout_hit)
                                phase_next = atapio_pkg::PH_IDLE;
                        end
                        else if (!drq)
                            phase_next = atapio_pkg::PH_IDLE;
                        else if (phase_reg == atapio_pkg::PH_RD_POLL)
                            phase_next = fin_done ? atapio_pkg::PH_IDLE
                                                  : atapio_pkg::PH_RD_WAIT_INT;
                        else if (expect_reg)
                            phase_next = atapio_pkg::PH_WR_WAIT_INT;
                        else
                            phase_next = fin_done ? atapio_pkg::PH_IDLE
                                                  : atapio_pkg::PH_WR_POLL;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Job and datapath registers
    always_comb
    begin
        logic do_finish;
        do_finish       = 1'b0;
        job             = '0;
        write_mode_next = write_mode_reg;
        slave_next      = slave_reg;
        cur_lba_next    = cur_lba_reg;
        rem_next        = rem_reg;
        chunk_next      = chunk_reg;
        poll_next       = poll_reg;
        expect_next     = expect_reg;
        if (acc)
        begin
            case (item.command)
                atapio_pkg::CMD_START:
                begin
                    if (start_bad)
                    begin
                        job.has_err  = 1'b1;
                        job.err_code = atapio_pkg::ERR_BAD_REQ;
                    end
                    else
                    begin
                        write_mode_next = item.is_write;
                        slave_next      = item.drive;
                        cur_lba_next    = item.lba;
                        rem_next        = item.sector_count;
                        chunk_next      = start_chunk;
                        poll_next       = 12'd0;
                        expect_next     = 1'b1;
                        job.has_dev     = 1'b1;
                        job.has_chunk   = 1'b1;
                        job.slave       = item.drive;
                        job.wr          = item.is_write;
                        job.count_byte  = start_chunk[7:0];
                        job.lba         = item.lba;
                    end
                end
                atapio_pkg::CMD_INTR:
                begin
                    if (expect_reg)
                    begin
                        expect_next = 1'b0;
                        job.has_ack = 1'b1;
                        if (phase_reg == atapio_pkg::PH_RD_WAIT_INT)
                            poll_next = 12'd0;
                        else if (phase_reg == atapio_pkg::PH_WR_WAIT_INT)
                            do_finish = 1'b1;
                    end
                end
                atapio_pkg::CMD_STAT:
                begin
                    if (polling)
                    begin
                        if (bsy)
                        begin
                            if (timeout_hit)
                            begin
                                expect_next  = 1'b0;
                                job.has_err  = 1'b1;
                                job.err_code = atapio_pkg::ERR_TIMEOUT;
                            end
                            else
                                poll_next = poll_inc[11:0];
                        end
                        else if (!drq)
                        begin
                            expect_next  = 1'b0;
                            job.has_err  = 1'b1;
                            job.err_code = atapio_pkg::ERR_NO_DRQ;
                        end
                        else
                        begin
                            job.has_burst = 1'b1;
                            job.burst_wr  = phase_reg == atapio_pkg::PH_WR_POLL;
                            job.words     = {chunk_reg, {atapio_pkg::SECTOR_SHIFT{1'b0}}};
                            // A write chunk whose interrupt is still due ends on it.
                            if (phase_reg == atapio_pkg::PH_RD_POLL || !expect_reg)
                                do_finish = 1'b1;
                        end
                    end
                end
                default:
                begin
                    job = '0;
                end
            endcase

            if (do_finish)
            begin
                rem_next = fin_rem;
                if (fin_done)
                    job.has_done = 1'b1;
                else
                begin
                    cur_lba_next   = fin_lba;
                    chunk_next     = fin_chunk;
                    poll_next      = 12'd0;
                    expect_next    = 1'b1;
                    job.has_chunk  = 1'b1;
                    job.slave      = slave_reg;
                    job.wr         = write_mode_reg;
                    job.count_byte = fin_chunk[7:0];
                    job.lba        = fin_lba;
                end
            end
        end
        push = acc && (job.has_err || job.has_ack || job.has_dev || job.has_burst
                       || job.has_chunk || job.has_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg    <= atapio_pkg::TIMEOUT_RESET;
            last_lba_reg   <= atapio_pkg::LAST_LBA_RESET;
            phase_reg      <= atapio_pkg::PH_IDLE;
            write_mode_reg <= 1'b0;
            slave_reg      <= 1'b0;
            cur_lba_reg    <= '0;
            rem_reg        <= '0;
            chunk_reg      <= '0;
            poll_reg       <= '0;
            expect_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == atapio_pkg::CFG_TIMEOUT)
                timeout_reg <= cfg_data[11:0];
            if (cfg_we && cfg_index == atapio_pkg::CFG_LAST_LBA)
                last_lba_reg <= cfg_data;
            phase_reg      <= phase_next;
            write_mode_reg <= write_mode_next;
            slave_reg      <= slave_next;
            cur_lba_reg    <= cur_lba_next;
            rem_reg        <= rem_next;
            chunk_reg      <= chunk_next;
            poll_reg       <= poll_next;
            expect_reg     <= expect_next;
        end
    end

endmodule

// File: rtl/atapio_queue.sv
// Short first-in first-out queue of jobs between the front and back parts.
// Depends on atapio_pkg for the job type.
module atapio_queue #(
    parameter int DEPTH = atapio_pkg::QUEUE_DEPTH_DEFAULT   // 2 or more
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  atapio_pkg::job_t push_job,
    input  logic             pop,
    output atapio_pkg::job_t head,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    atapio_pkg::job_t   slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full  = count_reg == CNT_W'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: rtl/atapio_back.sv
// Back part: takes one job at a time from the queue and issues its result words
// in order, one per cycle while the output is taken. Depends on atapio_pkg.
module atapio_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  atapio_pkg::job_t      head,
    input  logic                  empty,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output atapio_pkg::out_item_t out_data
);

    localparam int N = atapio_pkg::SLOT_N;

    atapio_pkg::job_t job_reg;
    logic [N-1:0]     slots_reg, slots_next;
    logic [3:0]       sel;
    logic [N-1:0]     remain, after;
    logic [7:0]       dev_byte;

    function automatic logic [N-1:0] slot_mask(input atapio_pkg::job_t j);
        logic [N-1:0] m;
        m = '0;
        m[atapio_pkg::SL_ERR]   = j.has_err;
        m[atapio_pkg::SL_ACK]   = j.has_ack;
        m[atapio_pkg::SL_DEV]   = j.has_dev;
        m[atapio_pkg::SL_BURST] = j.has_burst;
        m[atapio_pkg::SL_CNT]   = j.has_chunk;
        m[atapio_pkg::SL_LBA0]  = j.has_chunk;
        m[atapio_pkg::SL_LBA1]  = j.has_chunk;
        m[atapio_pkg::SL_LBA2]  = j.has_chunk;
        m[atapio_pkg::SL_DEVC]  = j.has_chunk;
        m[atapio_pkg::SL_CMD]   = j.has_chunk;
        m[atapio_pkg::SL_DONE]  = j.has_done;
        return m;
    endfunction

    // The lowest pending slot goes out next.
    always_comb
    begin
        sel = 4'd0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (slots_reg[i])
                sel = 4'(i);
        end
        remain = slots_reg & ~(N'(1) << sel);
    end

    assign out_valid = slots_reg != '0;
    assign dev_byte  = atapio_pkg::DEV_FIXED | atapio_pkg::DEV_LBA
                       | (job_reg.slave ? atapio_pkg::DEV_SLAVE : 8'd0);

    always_comb
    begin
        out_data      = '0;
        out_data.last = remain == '0;
        case (sel)
            atapio_pkg::SL_ERR:
            begin
                out_data.kind  = atapio_pkg::K_ERR;
                out_data.value = {6'd0, job_reg.err_code};
            end
            atapio_pkg::SL_ACK:
            begin
                out_data.kind       = atapio_pkg::K_ACK;
                out_data.reg_offset = atapio_pkg::REG_COMMAND;
            end
            atapio_pkg::SL_DEV:
            begin
                out_data.kind       = atapio_pkg::K_REG;
                out_data.reg_offset = atapio_pkg::REG_DRV_HEAD;
                out_data.value      = dev_byte;
            end
            atapio_pkg::SL_BURST:
            begin
                out_data.kind       = job_reg.burst_wr ? atapio_pkg::K_WBURST
                                                       : atapio_pkg::K_RBURST;
                out_data.word_count = job_reg.words;
            end
            atapio_pkg::SL_CNT:
            begin
                out_data.kind       = atapio_pkg::K_REG;
                out_data.reg_offset = atapio_pkg::REG_COUNT;
                out_data.value      = job_reg.count_byte;
            end
            atapio_pkg::SL_LBA0:
            begin
                out_data.kind       = atapio_pkg::K_REG;
                out_data.reg_offset = atapio_pkg::REG_LBA_LO;
                out_data.value      = job_reg.lba[7:0];
            end
            atapio_pkg::SL_LBA1:
            begin
                out_data.kind       = atapio_pkg::K_REG;
                out_data.reg_offset = atapio_pkg::REG_LBA_MID;
                out_data.value      = job_reg.lba[15:8];
            end
            atapio_pkg::SL_LBA2:
            begin
                out_data.kind       = atapio_pkg::K_REG;
                out_data.reg_offset = atapio_pkg::REG_LBA_HI;
                out_data.value      = job_reg.lba[23:16];
            end
            atapio_pkg::SL_DEVC:
            begin
                out_data.kind       = atapio_pkg::K_REG;
                out_data.reg_offset = atapio_pkg::REG_DRV_HEAD;
                out_data.value      = dev_byte | {4'd0, job_reg.lba[27:24]};
            end
            atapio_pkg::SL_CMD:
            begin
                out_data.kind       = atapio_pkg::K_REG;
                out_data.reg_offset = atapio_pkg::REG_COMMAND;
                out_data.value      = job_reg.wr ? atapio_pkg::ATA_WRITE
                                                 : atapio_pkg::ATA_READ;
            end
            atapio_pkg::SL_DONE:
            begin
                out_data.kind = atapio_pkg::K_DONE;
            end
            default:
            begin
                out_data.kind = atapio_pkg::K_REG;
            end
        endcase
    end

    always_comb
    begin
        after      = (out_valid && out_ready) ? remain : slots_reg;
        pop        = (after == '0) && !empty;
        slots_next = pop ? slot_mask(head) : after;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slots_reg <= '0;
        else
            slots_reg <= slots_next;
    end

endmodule

// File: rtl/ata_pio_transfer_sequencer.sv
// Top level of the ATA PIO LBA28 host transfer sequencer.
// Instantiates atapio_front, atapio_queue and atapio_back; uses atapio_pkg.
//
//  Channel   Signals                         Moves
//  input     in_valid / in_ready / in_data   one event word (start, interrupt, status)
//  output    out_valid / out_ready / out_data one result word
//  config    cfg_we / cfg_index / cfg_data   register write, no handshake
//
// An input word is taken every cycle while the job queue has room; its state update
// is done in that cycle. A job leaves as one to seven result words, one per cycle
// when taken, so the sustained rate is set by the back part's result count per job.
// The queue of QUEUE_DEPTH jobs lets input and output stall independently.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
module ata_pio_transfer_sequencer #(
    parameter int QUEUE_DEPTH = atapio_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [27:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  atapio_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output atapio_pkg::out_item_t out_data
);

    logic             push, pop, full, empty;
    atapio_pkg::job_t push_job, head;

    assign in_ready = !full;

    atapio_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .acc       (in_valid && in_ready),
        .item      (in_data),
        .push      (push),
        .job       (push_job)
    );

    atapio_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    atapio_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: verif/ata_pio_transfer_sequencer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the ATA PIO LBA28 transfer sequencer: directed words, then
// mostly well-formed random transfers under several register settings, with random stalls.
// Depends on rtl/atapio_pkg.sv and rtl/ata_pio_transfer_sequencer.sv.
module ata_pio_transfer_sequencer_tb;
    import atapio_pkg::*;

    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam int unsigned LBA_TOP       = 32'h0FFF_FFFF;
    localparam int          SETTLE_CYCLES = 32;
    localparam int          CYCLE_LIMIT   = 1_000_000;

    // Shadow of the sequencer: predicts the result words of every accepted input word.
    class xfer_scoreboard;
        out_item_t   expected_q[$];
        int          failures;
        logic [11:0] timeout_polls;
        logic [27:0] last_lba;
        phase_t      phase;
        logic        write_mode;
        logic        slave_sel;
        logic        want_intr;
        logic [27:0] base_lba;
        logic [15:0] total;
        logic [15:0] done_cnt;
        logic [8:0]  chunk;
        logic [11:0] polls;

        function new();
            failures = 0;
            timeout_polls = TIMEOUT_RESET;
            last_lba = LAST_LBA_RESET;
            phase = PH_IDLE;
            write_mode = 1'b0;
            slave_sel = 1'b0;
            want_intr = 1'b0;
            base_lba = '0;
            total = '0;
            done_cnt = '0;
            chunk = '0;
            polls = '0;
        endfunction

        function void write_regs(logic [11:0] t, logic [27:0] l);
            timeout_polls = t;
            last_lba = l;
        endfunction

        function void push(logic [2:0] k, logic [2:0] off, logic [7:0] val, logic [16:0] words);
            out_item_t r;
            r.kind = k;
            r.reg_offset = off;
            r.value = val;
            r.word_count = words;
            r.last = 1'b0;
            expected_q.push_back(r);
        endfunction

        function void issue_chunk();
            logic [15:0] left;
            logic [27:0] lba;
            logic [7:0]  dev;
            left = total - done_cnt;
            lba = base_lba + 28'(done_cnt);
            chunk = (left > 16'(MAX_CHUNK_SECTORS)) ? MAX_CHUNK_SECTORS : left[8:0];
            polls = '0;
            dev = DEV_FIXED | DEV_LBA | (slave_sel ? DEV_SLAVE : 8'h00) | {4'h0, lba[27:24]};
            // A full chunk of 256 sectors goes out as a count byte of zero.
            push(K_REG, REG_COUNT, chunk[7:0], '0);
            push(K_REG, REG_LBA_LO, lba[7:0], '0);
            push(K_REG, REG_LBA_MID, lba[15:8], '0);
            push(K_REG, REG_LBA_HI, lba[23:16], '0);
            push(K_REG, REG_DRV_HEAD, dev, '0);
            push(K_REG, REG_COMMAND, write_mode ? ATA_WRITE : ATA_READ, '0);
            want_intr = 1'b1;
            if (write_mode)
                phase = PH_WR_POLL;
            else
                phase = PH_RD_WAIT_INT;
        endfunction

        function void finish_chunk();
            done_cnt = done_cnt + 16'(chunk);
            if (done_cnt >= total)
            begin
                phase = PH_IDLE;
                push(K_DONE, REG_NONE, '0, '0);
            end
            else
                issue_chunk();
        endfunction

        function void abort(logic [1:0] code);
            phase = PH_IDLE;
            want_intr = 1'b0;
            push(K_ERR, REG_NONE, {6'd0, code}, '0);
        endfunction

        // Returns the number of result words that the input word causes.
        function int note_input(in_item_t w);
            int          first;
            int unsigned end_sector;
            first = expected_q.size();
            end_sector = 32'(w.lba) + 32'(w.sector_count) - 1;
            case (w.command)
                CMD_START:
                begin
                    if (phase != PH_IDLE || w.sector_count == 0 || w.lba > last_lba ||
                        end_sector > LBA_TOP)
                        push(K_ERR, REG_NONE, {6'd0, ERR_BAD_REQ}, '0);
                    else
                    begin
                        write_mode = w.is_write;
                        slave_sel = w.drive;
                        base_lba = w.lba;
                        total = w.sector_count;
                        done_cnt = '0;
                        push(K_REG, REG_DRV_HEAD,
                             DEV_FIXED | DEV_LBA | (slave_sel ? DEV_SLAVE : 8'h00), '0);
                        issue_chunk();
                    end
                end
                CMD_INTR:
                begin
                    if (want_intr)
                    begin
                        want_intr = 1'b0;
                        push(K_ACK, REG_COMMAND, '0, '0);
                        if (phase == PH_RD_WAIT_INT)
                        begin
                            phase = PH_RD_POLL;
                            polls = '0;
                        end
                        else if (phase == PH_WR_WAIT_INT)
                            finish_chunk();
                    end
                end
                CMD_STAT:
                begin
                    if (phase == PH_RD_POLL || phase == PH_WR_POLL)
                    begin
                        if ((w.status_byte & STAT_BSY) != 0)
                        begin
                            if (13'(polls) + 13'd1 >= 13'(timeout_polls))
                                abort(ERR_TIMEOUT);
                            else
                                polls = polls + 12'd1;
                        end
                        else if ((w.status_byte & STAT_DRQ) == 0)
                            abort(ERR_NO_DRQ);
                        else if (phase == PH_RD_POLL)
                        begin
                            push(K_RBURST, REG_NONE, '0, {chunk, 8'h00});
                            finish_chunk();
                        end
                        else
                        begin
                            push(K_WBURST, REG_NONE, '0, {chunk, 8'h00});
                            // An interrupt seen while polling lets the chunk end at once.
                            if (want_intr)
                                phase = PH_WR_WAIT_INT;
                            else
                                finish_chunk();
                        end
                    end
                end
                default: ;
            endcase
            if (expected_q.size() > first)
                expected_q[expected_q.size() - 1].last = 1'b1;
            return expected_q.size() - first;
        endfunction

        function void compare_field(string name, logic [16:0] want, logic [16:0] seen);
            if (seen !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, seen);
                failures++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result word: kind %0d value %0d", got.kind, got.value);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("kind", 17'(want.kind), 17'(got.kind));
            compare_field("reg_offset", 17'(want.reg_offset), 17'(got.reg_offset));
            compare_field("value", 17'(want.value), 17'(got.value));
            compare_field("word_count", want.word_count, got.word_count);
            compare_field("last", 17'(want.last), 17'(got.last));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_TIMEOUT;
    logic [27:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    int          ready_hold = 0;
    int          cycle_count = 0;
    int          steady_words = 0;

    xfer_scoreboard sb = new();

    ata_pio_transfer_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [27:0] pick_lba();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 28'($urandom_range(0, sb.last_lba));
        if (r < 85)
            return sb.last_lba;
        return 28'(LBA_TOP - $urandom_range(0, 300));
    endfunction

    // Mostly short transfers; now and then one of many chunks.
    function automatic logic [15:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 16'($urandom_range(1, 300));
        if (r < 80)
            return 16'($urandom_range(1, 8));
        if (r < 95)
            return 16'($urandom_range(255, 1030));
        return 16'($urandom_range(1, 65535));
    endfunction

    function automatic logic [7:0] pick_status();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return STAT_BSY | 8'($urandom);
        if (r < 90)
            return (8'($urandom) & ~STAT_BSY) | STAT_DRQ;
        return 8'($urandom) & ~(STAT_BSY | STAT_DRQ);
    endfunction

    // Picks the word that the drive would plausibly send next, with some noise.
    function automatic in_item_t next_word();
        in_item_t w;
        w.command = 2'($urandom_range(0, 3));
        w.is_write = 1'($urandom);
        w.drive = 1'($urandom);
        w.lba = 28'($urandom);
        w.sector_count = 16'($urandom);
        w.status_byte = 8'($urandom);
        if ($urandom_range(0, 99) < 12)
            return w;
        case (sb.phase)
            PH_IDLE:
            begin
                w.command = CMD_START;
                w.lba = pick_lba();
                w.sector_count = pick_count();
            end
            PH_RD_WAIT_INT, PH_WR_WAIT_INT:
                w.command = CMD_INTR;
            PH_WR_POLL:
            begin
                if (sb.want_intr && $urandom_range(0, 99) < 20)
                    w.command = CMD_INTR;
                else
                begin
                    w.command = CMD_STAT;
                    w.status_byte = pick_status();
                end
            end
            default:
            begin
                w.command = CMD_STAT;
                w.status_byte = pick_status();
            end
        endcase
        return w;
    endfunction

    function automatic in_item_t mk(logic [1:0] cmd, logic wr, logic drv, logic [27:0] lba,
                                    logic [15:0] cnt, logic [7:0] st);
        in_item_t w;
        w.command = cmd;
        w.is_write = wr;
        w.drive = drv;
        w.lba = lba;
        w.sector_count = cnt;
        w.status_byte = st;
        return w;
    endfunction

    task automatic send_word(input in_item_t w);
        int gap;
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        void'(sb.note_input(w));
        if (steady_words > 0)
        begin
            steady_words--;
            gap = 0;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 99) < 3)
                steady_words = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_plan(input in_item_t plan[$]);
        foreach (plan[i])
            send_word(plan[i]);
    endtask

    task automatic run_random(input int n);
        repeat (n)
            send_word(next_word());
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [11:0] polls, input logic [27:0] top_lba);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TIMEOUT;
        cfg_data <= 28'(polls);
        @(posedge clk);
        cfg_index <= CFG_LAST_LBA;
        cfg_data <= top_lba;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_regs(polls, top_lba);
    endtask

    // Receiver: short stalls mostly, a few long ones, and stretches with none.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_hold <= 0;
        end
        else if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else if (!out_ready || $urandom_range(0, 99) < 5)
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 10)
                ready_hold <= $urandom_range(100, 300);
            else
                ready_hold <= $urandom_range(0, 12);
        end
        else
        begin
            out_ready <= 1'b0;
            ready_hold <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ata_pio_transfer_sequencer_tb failed");
            $finish;
        end
    end

    initial
    begin
        in_item_t plan[$];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register values after reset: bad requests, ignored words, two reads and a write.
        plan.push_back(mk(CMD_START, 1'b0, 1'b0, 28'd0, 16'd0, 8'h00));
        plan.push_back(mk(CMD_START, 1'b0, 1'b0, 28'd163840, 16'd1, 8'h00));
        plan.push_back(mk(CMD_INTR, 1'b1, 1'b1, 28'hFFFFFFF, 16'hFFFF, 8'hFF));
        plan.push_back(mk(CMD_STAT, 1'b0, 1'b0, 28'd0, 16'd0, 8'h08));
        plan.push_back(mk(CMD_UNUSED, 1'b1, 1'b1, 28'd5, 16'd5, 8'h08));
        plan.push_back(mk(CMD_START, 1'b0, 1'b1, 28'd163839, 16'd1, 8'h00));
        plan.push_back(mk(CMD_START, 1'b1, 1'b0, 28'd10, 16'd4, 8'h00));
        plan.push_back(mk(CMD_STAT, 1'b0, 1'b0, 28'd0, 16'd0, 8'h08));
        plan.push_back(mk(CMD_INTR, 1'b0, 1'b0, 28'd0, 16'd0, 8'h00));
        plan.push_back(mk(CMD_STAT, 1'b0, 1'b0, 28'd0, 16'd0, 8'hFF));
        plan.push_back(mk(CMD_STAT, 1'b0, 1'b0, 28'd0, 16'd0, 8'h08));
        plan.push_back(mk(CMD_START, 1'b1, 1'b0, 28'd0, 16'd300, 8'h00));
        plan.push_back(mk(CMD_STAT, 1'b0, 1'b0, 28'd0, 16'd0, 8'h58));
        plan.push_back(mk(CMD_INTR, 1'b0, 1'b0, 28'd0, 16'd0, 8'h00));
        plan.push_back(mk(CMD_INTR, 1'b0, 1'b0, 28'd0, 16'd0, 8'h00));
        plan.push_back(mk(CMD_STAT, 1'b0, 1'b0, 28'd0, 16'd0, 8'h08));
        plan.push_back(mk(CMD_START, 1'b0, 1'b0, 28'd1000, 16'd256, 8'h00));
        plan.push_back(mk(CMD_INTR, 1'b0, 1'b0, 28'd0, 16'd0, 8'h00));
        plan.push_back(mk(CMD_STAT, 1'b0, 1'b0, 28'd0, 16'd0, 8'h77));
        send_plan(plan);
        settle();

        // Shortest timeout and the whole address space: top sectors and the edge of the space.
        program_regs(12'd1, 28'(LBA_TOP));
        plan.delete();
        plan.push_back(mk(CMD_START, 1'b0, 1'b1, 28'hFFFFFFF, 16'd1, 8'h00));
        plan.push_back(mk(CMD_INTR, 1'b0, 1'b0, 28'd0, 16'd0, 8'h00));
        plan.push_back(mk(CMD_STAT, 1'b0, 1'b0, 28'd0, 16'd0, 8'h80));
        plan.push_back(mk(CMD_START, 1'b0, 1'b0, 28'hFFFFFFF, 16'd2, 8'h00));
        plan.push_back(mk(CMD_START, 1'b1, 1'b1, 28'hFFFFF01, 16'hFFFF, 8'h00));
        plan.push_back(mk(CMD_START, 1'b1, 1'b1, 28'hFFFFF00, 16'd256, 8'h00));
        send_plan(plan);
        run_random(25);
        settle();

        program_regs(12'd4095, 28'd0);
        run_random(25);
        settle();

        program_regs(12'($urandom_range(2, 12)), 28'($urandom_range(1000, LBA_TOP)));
        run_random(25);
        settle();

        program_regs(TIMEOUT_RESET, LAST_LBA_RESET);
        run_random(25);
        settle();

        program_regs(12'($urandom_range(1, 20)), 28'(LBA_TOP));
        run_random(25);
        settle();

        if (sb.failures == 0)
            $display("ata_pio_transfer_sequencer_tb passed");
        else
            $display("ata_pio_transfer_sequencer_tb failed");
        $finish;
    end

endmodule
